>>> hw/rtl/vab_pkg.sv
// ----------------------------------------------------------------------------
// Vector angle bisection package
// Shared constants, the quadrant fold flags and the elaboration-time
// functions that build the tangent tables used by the bisection cells.
// ----------------------------------------------------------------------------
package vab_pkg;

   localparam int TAN_FRAC     = 24;
   localparam int TAN_W        = 33;
   localparam int ANGLE_W      = 12;
   localparam int QUARTER_BITS = 10;

   localparam logic [TAN_W-1:0]   TAN_MAX       = '1;
   localparam logic [ANGLE_W:0]   FULL_STEPS    = 13'd4096;
   localparam logic [ANGLE_W-1:0] HALF_STEPS    = 12'd2048;
   localparam logic [ANGLE_W-1:0] QUARTER_STEPS = 12'd1024;

   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C234;

   // quadrant of the difference vector, carried alongside the bisection
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero_x;
      logic zero_y;
   } vab_fold_type;

   // Q2.62 product, truncated
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[125:62];
   endfunction

   // long division, returns {remainder, quotient}
   function automatic logic [127:0] divmod64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return {rem[63:0], quo};
   endfunction

   // sine and cosine series in Q2.62, returns {sin, cos}
   function automatic logic [127:0] sin_cos_q62(logic [63:0] a);
      logic [63:0]  a2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  s;
      logic [63:0]  dv;
      logic [127:0] dm;
      a2   = mul_q62(a, a);
      term = a;
      sum  = a;
      for (int i = 1; i < 40; i++) begin
         if (term != 64'd0) begin
            dv   = 64'((2 * i) * (2 * i + 1));
            dm   = divmod64(mul_q62(term, a2), dv);
            term = dm[63:0];
            if (i[0]) sum = sum - term;
            else      sum = sum + term;
         end
      end
      s    = sum;
      term = ONE_Q62;
      sum  = ONE_Q62;
      for (int i = 1; i < 40; i++) begin
         if (term != 64'd0) begin
            dv   = 64'((2 * i - 1) * (2 * i));
            dm   = divmod64(mul_q62(term, a2), dv);
            term = dm[63:0];
            if (i[0]) sum = sum - term;
            else      sum = sum + term;
         end
      end
      return {s, sum};
   endfunction

   // num/den as unsigned Q9.24, rounded half up, saturated
   function automatic logic [TAN_W-1:0] ratio_q24(logic [63:0] num, logic [63:0] den);
      logic [127:0] dm;
      logic [63:0]  q;
      logic [63:0]  rem;
      if (den == 64'd0) return TAN_MAX;
      dm  = divmod64(num, den);
      q   = dm[63:0];
      rem = dm[127:64];
      if (q > 64'(TAN_MAX >> TAN_FRAC)) return TAN_MAX;
      for (int i = 0; i < TAN_FRAC + 1; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q   = q | 64'd1;
         end
      end
      q = (q + 64'd1) >> 1;
      if (q > 64'(TAN_MAX)) return TAN_MAX;
      return TAN_W'(q);
   endfunction

   // tangent of m * (PI/2) / 2^(steps+1), cotangent symmetry above PI/4
   function automatic logic [TAN_W-1:0] tan_rom(logic [63:0] m, int steps);
      logic [63:0]  half;
      logic [63:0]  r;
      logic [127:0] p;
      logic [63:0]  a;
      logic [127:0] sc;
      half = 64'd1 << steps;
      r    = (m <= half) ? m : (half << 1) - m;
      p    = {64'b0, PI_Q62} * {64'b0, r};
      p    = p >> (steps + 2);
      a    = p[63:0];
      sc   = sin_cos_q62(a);
      if (m <= half) return ratio_q24(sc[127:64], sc[63:0]);
      return ratio_q24(sc[63:0], sc[127:64]);
   endfunction

endpackage

>>> hw/rtl/vab_front.sv
// ----------------------------------------------------------------------------
// Vector angle front stage
// Subtracts the origin, folds the difference onto the first quadrant and
// registers magnitudes and quadrant flags.
// ----------------------------------------------------------------------------
module vab_front import vab_pkg::*; #(
   parameter int COORD_WIDTH  = 16,
   parameter int BISECT_STEPS = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  logic [COORD_WIDTH-1:0]  point_x,
   input  logic [COORD_WIDTH-1:0]  point_y,
   input  logic [COORD_WIDTH-1:0]  origin_x,
   input  logic [COORD_WIDTH-1:0]  origin_y,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output logic [COORD_WIDTH-1:0]  dn_mag_x,
   output logic [COORD_WIDTH-1:0]  dn_mag_y,
   output logic [BISECT_STEPS:0]   dn_low,
   output vab_fold_type            dn_fold
);

   logic [COORD_WIDTH:0]   dx;
   logic [COORD_WIDTH:0]   dy;
   logic [COORD_WIDTH:0]   abs_x;
   logic [COORD_WIDTH:0]   abs_y;
   vab_fold_type           fold_in;
   logic                   valid_ff;
   logic [COORD_WIDTH-1:0] mag_x_ff;
   logic [COORD_WIDTH-1:0] mag_y_ff;
   vab_fold_type           fold_ff;

   // differences are exact one bit wider than the coordinates
   assign dx = {point_x[COORD_WIDTH-1], point_x} - {origin_x[COORD_WIDTH-1], origin_x};
   assign dy = {point_y[COORD_WIDTH-1], point_y} - {origin_y[COORD_WIDTH-1], origin_y};

   assign abs_x = dx[COORD_WIDTH] ? -dx : dx;
   assign abs_y = dy[COORD_WIDTH] ? -dy : dy;

   always_comb begin
      fold_in.neg_x  = dx[COORD_WIDTH];
      fold_in.neg_y  = dy[COORD_WIDTH];
      fold_in.zero_x = (dx == '0);
      fold_in.zero_y = (dy == '0);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         mag_x_ff <= abs_x[COORD_WIDTH-1:0];
         mag_y_ff <= abs_y[COORD_WIDTH-1:0];
         fold_ff  <= fold_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_mag_x = mag_x_ff;
   assign dn_mag_y = mag_y_ff;
   assign dn_low   = '0;
   assign dn_fold  = fold_ff;

endmodule

>>> hw/rtl/vab_cell.sv
// ----------------------------------------------------------------------------
// Vector angle bisection cell
// One bisection step: compares y against x times the tangent of the
// interval midpoint and keeps the lower or upper half.
// ----------------------------------------------------------------------------
module vab_cell import vab_pkg::*; #(
   parameter int COORD_WIDTH  = 16,
   parameter int BISECT_STEPS = 9,
   parameter int STAGE        = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  logic [COORD_WIDTH-1:0]  up_mag_x,
   input  logic [COORD_WIDTH-1:0]  up_mag_y,
   input  logic [BISECT_STEPS:0]   up_low,
   input  vab_fold_type            up_fold,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output logic [COORD_WIDTH-1:0]  dn_mag_x,
   output logic [COORD_WIDTH-1:0]  dn_mag_y,
   output logic [BISECT_STEPS:0]   dn_low,
   output vab_fold_type            dn_fold
);

   localparam int ENTRIES = 1 << STAGE;
   localparam int PROD_W  = COORD_WIDTH + TAN_W;
   localparam logic [BISECT_STEPS:0] MID_BIT =
      {{BISECT_STEPS{1'b0}}, 1'b1} << (BISECT_STEPS - STAGE);

   typedef logic [TAN_W-1:0] rom_type [ENTRIES];

   // only the midpoints this step can see: low carries STAGE decided bits
   function automatic rom_type build_rom();
      rom_type r;
      for (int j = 0; j < ENTRIES; j++) begin
         r[j] = tan_rom(64'((2 * j + 1)) << (BISECT_STEPS - STAGE), BISECT_STEPS);
      end
      return r;
   endfunction

   localparam rom_type TAN_ROM = build_rom();

   logic [TAN_W-1:0]       tan_val;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]      lhs;
   logic                   below;
   logic [BISECT_STEPS:0]  low_in;
   logic                   valid_ff;
   logic [COORD_WIDTH-1:0] mag_x_ff;
   logic [COORD_WIDTH-1:0] mag_y_ff;
   logic [BISECT_STEPS:0]  low_ff;
   vab_fold_type           fold_ff;

   generate
      if (STAGE == 0) begin : g_first
         assign tan_val = TAN_ROM[0];
      end else begin : g_rest
         assign tan_val = TAN_ROM[up_low[BISECT_STEPS -: STAGE]];
      end
   endgenerate

   assign prod   = {{TAN_W{1'b0}}, up_mag_x} * {{COORD_WIDTH{1'b0}}, tan_val};
   assign lhs    = {{(TAN_W - TAN_FRAC){1'b0}}, up_mag_y, {TAN_FRAC{1'b0}}};
   assign below  = lhs < prod;
   // keep the lower half when below, else move low up to the midpoint
   assign low_in = below ? up_low : (up_low | MID_BIT);

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         mag_x_ff <= up_mag_x;
         mag_y_ff <= up_mag_y;
         low_ff   <= low_in;
         fold_ff  <= up_fold;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_mag_x = mag_x_ff;
   assign dn_mag_y = mag_y_ff;
   assign dn_low   = low_ff;
   assign dn_fold  = fold_ff;

endmodule

>>> hw/rtl/vab_back.sv
// ----------------------------------------------------------------------------
// Vector angle back stage
// Scales the final midpoint to PI/2048 steps, applies the special cases,
// unfolds the quadrant and holds the result in the output register.
// ----------------------------------------------------------------------------
module vab_back import vab_pkg::*; #(
   parameter int BISECT_STEPS = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [BISECT_STEPS:0] up_low,
   input  vab_fold_type          up_fold,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [ANGLE_W-1:0]    dn_angle
);

   localparam int UP    = BISECT_STEPS + 1;
   localparam int EXT_W = UP + ANGLE_W;

   logic [BISECT_STEPS:0] mid;
   logic [EXT_W-1:0]      mid_ext;
   logic [EXT_W-1:0]      scaled;
   logic [ANGLE_W-1:0]    base;
   logic [ANGLE_W-1:0]    half_turn;
   logic [ANGLE_W-1:0]    angle_in;
   logic                  valid_ff;
   logic [ANGLE_W-1:0]    angle_ff;

   // final interval is two units wide, its midpoint is low + 1
   assign mid     = up_low + {{BISECT_STEPS{1'b0}}, 1'b1};
   assign mid_ext = {{ANGLE_W{1'b0}}, mid};

   generate
      if (UP <= QUARTER_BITS) begin : g_widen
         assign scaled = mid_ext << (QUARTER_BITS - UP);
      end else begin : g_trunc
         assign scaled = mid_ext >> (UP - QUARTER_BITS);
      end
   endgenerate

   always_comb begin
      if (up_fold.zero_x) begin
         base = QUARTER_STEPS;
      end else if (up_fold.zero_y) begin
         base = '0;
      end else begin
         base = scaled[ANGLE_W-1:0];
      end
      half_turn = up_fold.neg_x ? (HALF_STEPS - base) : base;
      angle_in  = up_fold.neg_y ? ANGLE_W'(FULL_STEPS - {1'b0, half_turn}) : half_turn;
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         angle_ff <= angle_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_angle = angle_ff;

endmodule

>>> hw/rtl/vector_angle_bisection.sv
// ----------------------------------------------------------------------------
// Vector angle bisection
// Clockwise angle of (point - origin) in screen axes, in PI/2048 steps.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock unless the result side stalls, and
// returns one angle per transfer, in order, through the front stage, one
// cell per bisection step and the output register. Throughput is one item
// per cycle unless the result side stalls, set by the cell chain: every
// cell holds one item and does one bisection step, a single COORD_WIDTH by
// 33-bit multiply and a compare against a tangent constant from its own small
// table. Each stage takes a new item whenever it is empty or its neighbor
// takes its content, so bubbles close up and input keeps flowing while a
// finished result waits, until every stage is full. The angle is zero
// along plus x and grows clockwise with y pointing down; the zero vector and
// any vector with dx zero and dy not negative read as a quarter turn (1024).
module vector_angle_bisection import vab_pkg::*; #(
   parameter int COORD_WIDTH  = 16,
   parameter int BISECT_STEPS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // point_x, point_y, origin_x, origin_y (COORD_WIDTH bits each), zero pad
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // angle_steps (12 bits), zero pad
   output logic [15:0]                   rsp_tdata
);

   localparam int CELLS = BISECT_STEPS;

   // chain links: index 0 is the front stage output, CELLS the last cell
   logic                   link_valid [CELLS+1];
   logic                   link_ready [CELLS+1];
   logic [COORD_WIDTH-1:0] link_mag_x [CELLS+1];
   logic [COORD_WIDTH-1:0] link_mag_y [CELLS+1];
   logic [BISECT_STEPS:0]  link_low   [CELLS+1];
   vab_fold_type           link_fold  [CELLS+1];
   logic [ANGLE_W-1:0]     angle;

   // subtract origin, fold onto the first quadrant
   vab_front #(
      .COORD_WIDTH  (COORD_WIDTH),
      .BISECT_STEPS (BISECT_STEPS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .point_x  (req_tdata[COORD_WIDTH-1:0]),
      .point_y  (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .origin_x (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .origin_y (req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_mag_x (link_mag_x[0]),
      .dn_mag_y (link_mag_y[0]),
      .dn_low   (link_low[0]),
      .dn_fold  (link_fold[0])
   );

   // one cell per bisection step, each halving the interval once
   generate
      for (genvar k = 0; k < CELLS; k++) begin : g_cell
         vab_cell #(
            .COORD_WIDTH  (COORD_WIDTH),
            .BISECT_STEPS (BISECT_STEPS),
            .STAGE        (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_mag_x (link_mag_x[k]),
            .up_mag_y (link_mag_y[k]),
            .up_low   (link_low[k]),
            .up_fold  (link_fold[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_mag_x (link_mag_x[k+1]),
            .dn_mag_y (link_mag_y[k+1]),
            .dn_low   (link_low[k+1]),
            .dn_fold  (link_fold[k+1])
         );
      end
   endgenerate

   // scale the midpoint, apply special cases, unfold, hold for transfer
   vab_back #(
      .BISECT_STEPS (BISECT_STEPS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (link_valid[CELLS]),
      .up_ready (link_ready[CELLS]),
      .up_low   (link_low[CELLS]),
      .up_fold  (link_fold[CELLS]),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_angle (angle)
   );

   assign rsp_tdata = {{(16 - ANGLE_W){1'b0}}, angle};

endmodule
